/* rtl/set_assoc_lru_cache_lookup_macros.svh */
// Assertion macros used by the checker of the cache lookup block.
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/salc_pkg.sv */
// Package: shared constants, handshake structs and helpers of the cache lookup block.
`timescale 1ns / 1ps
package salc_pkg;

	localparam int ADDR_W = 64;
	localparam int CNT_W  = 32;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_WAYS       = 2'd1;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

	localparam logic [3:0] RST_SET_BITS   = 4'd4;
	localparam logic [3:0] RST_WAYS       = 4'd1;
	localparam logic [5:0] RST_BLOCK_BITS = 6'd4;

	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_FILL  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	localparam logic KIND_MODIFY = 1'b1;

	typedef struct packed {
		logic clr;      // write a cleared row at the sweep pointer
		logic capture;  // take the input word, read its set
		logic reread;   // read the held set again
		logic look;     // resolve lookup, write back, load result
		logic last;     // result closes the input word
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_free;
	} stat_t;

	function automatic logic [ADDR_W-1:0] shr64(logic [ADDR_W-1:0] x, logic [6:0] n);
		if (n >= 7'(ADDR_W)) begin
			return '0;
		end
		return x >> n[5:0];
	endfunction

endpackage

/* rtl/salc_cfg.sv */
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module salc_cfg
	import salc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  set_bits,
	output logic [3:0]  ways_in_use,
	output logic [5:0]  block_bits
);

	logic wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits    <= RST_SET_BITS;
			ways_in_use <= RST_WAYS;
			block_bits  <= RST_BLOCK_BITS;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_SET_BITS:   set_bits    <= pwdata[3:0];
				REG_WAYS:       ways_in_use <= pwdata[3:0];
				REG_BLOCK_BITS: block_bits  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SET_BITS:   prdata = {28'd0, set_bits};
			REG_WAYS:       prdata = {28'd0, ways_in_use};
			REG_BLOCK_BITS: prdata = {26'd0, block_bits};
			default:        prdata = '0;
		endcase
	end

endmodule

/* rtl/salc_ctrl.sv */
// Controller: sequences clearing sweep, capture and the one or two lookups per word.
`timescale 1ns / 1ps
module salc_ctrl
	import salc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  logic  s_tuser,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_LOOK   = 4'b0100,
		ST_REREAD = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   modify_q, second_q;
	logic   acc;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid & s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.capture = acc;
				if (acc) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if (stat.out_free) begin
					cmd.look = 1'b1;
					cmd.last = !(modify_q && !second_q);
					state_d  = (modify_q && !second_q) ? ST_REREAD : ST_IDLE;
				end
			end
			ST_REREAD: begin
				cmd.reread = 1'b1;
				state_d    = ST_LOOK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			modify_q <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				modify_q <= (s_tuser == KIND_MODIFY);
				second_q <= 1'b0;
			end else if (cmd.look) begin
				second_q <= 1'b1;
			end
		end
	end

endmodule

/* rtl/salc_dp.sv */
// Datapath: set memory, way search, LRU rank update, counters and result register.
`timescale 1ns / 1ps
module salc_dp
	import salc_pkg::*;
#(
	parameter int MAX_SET_BITS = 10,
	parameter int MAX_WAYS     = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [3:0]        set_bits,
	input  logic [3:0]        ways_in_use,
	input  logic [5:0]        block_bits,
	input  logic [ADDR_W-1:0] in_addr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_outcome,
	output logic              out_last,
	output logic [CNT_W-1:0]  out_hits,
	output logic [CNT_W-1:0]  out_misses,
	output logic [CNT_W-1:0]  out_evicts
);

	localparam int NSETS = 1 << MAX_SET_BITS;
	localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WW    = RW;

	typedef logic [MAX_WAYS-1:0][RW-1:0]     rank_row_t;
	typedef logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_row_t;

	logic [MAX_WAYS-1:0] v_mem [NSETS];
	rank_row_t           r_mem [NSETS];
	tag_row_t            t_mem [NSETS];

	logic [MAX_WAYS-1:0]     v_q;
	rank_row_t               r_q;
	tag_row_t                t_q;
	logic [MAX_SET_BITS-1:0] set_q, set_in, clr_q, rd_addr;
	logic [ADDR_W-1:0]       tag_q, tag_in;
	logic [4:0]              s_eff, e_eff;
	logic [MAX_WAYS-1:0]     in_use;

	logic                hit, inv;
	logic [WW-1:0]       hit_idx, inv_idx, vic_idx, sel;
	logic [RW-1:0]       best;
	logic [RW:0]         old;
	logic [MAX_WAYS-1:0] v_new;
	rank_row_t           r_new;
	tag_row_t            t_new;
	logic [1:0]          outcome;

	logic [CNT_W-1:0] hits_q, miss_q, evict_q;

	// address split
	always_comb begin
		s_eff = ({1'b0, set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, set_bits};
		tag_in = shr64(in_addr, 7'(block_bits) + 7'(s_eff));
		set_in = MAX_SET_BITS'(shr64(in_addr, {1'b0, block_bits}));
		for (int i = 0; i < MAX_SET_BITS; i++) begin
			if (5'(i) >= s_eff) set_in[i] = 1'b0;
		end
		e_eff = (ways_in_use == 4'd0) ? 5'd1 : {1'b0, ways_in_use};
		if (e_eff > 5'(MAX_WAYS)) e_eff = 5'(MAX_WAYS);
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w] = 5'(w) < e_eff;
		end
	end

	assign rd_addr = cmd.capture ? set_in : set_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_q <= set_in;
			tag_q <= tag_in;
		end
		if (cmd.capture || cmd.reread) begin
			v_q <= v_mem[rd_addr];
			r_q <= r_mem[rd_addr];
			t_q <= t_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			v_mem[clr_q] <= '0;
			r_mem[clr_q] <= '0;
		end else if (cmd.look) begin
			v_mem[set_q] <= v_new;
			r_mem[set_q] <= r_new;
			t_mem[set_q] <= t_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign stat.clr_done = (clr_q == {MAX_SET_BITS{1'b1}});
	assign stat.out_free = !out_valid || out_ready;

	// way search and LRU update
	always_comb begin
		hit     = 1'b0;
		inv     = 1'b0;
		hit_idx = '0;
		inv_idx = '0;
		vic_idx = '0;
		best    = r_q[0];
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (in_use[w] && v_q[w] && t_q[w] == tag_q && !hit) begin
				hit     = 1'b1;
				hit_idx = WW'(w);
			end
			if (in_use[w] && !v_q[w] && !inv) begin
				inv     = 1'b1;
				inv_idx = WW'(w);
			end
		end
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && r_q[w] > best) begin
				best    = r_q[w];
				vic_idx = WW'(w);
			end
		end
		sel     = hit ? hit_idx : (inv ? inv_idx : vic_idx);
		outcome = hit ? OUT_HIT : (inv ? OUT_FILL : OUT_EVICT);
		old     = v_q[sel] ? {1'b0, r_q[sel]} : (RW+1)'(MAX_WAYS);
		v_new   = v_q;
		r_new   = r_q;
		t_new   = t_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WW'(w) != sel && v_q[w] && {1'b0, r_q[w]} < old &&
			    {1'b0, r_q[w]} < (RW+1)'(MAX_WAYS - 1)) begin
				r_new[w] = r_q[w] + 1'b1;
			end
		end
		r_new[sel] = '0;
		v_new[sel] = 1'b1;
		t_new[sel] = tag_q;
	end

	// counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			miss_q    <= '0;
			evict_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.look) begin
				if (hit && hits_q != '1) hits_q <= hits_q + 1'b1;
				if (!hit && miss_q != '1) miss_q <= miss_q + 1'b1;
				if (!hit && !inv && evict_q != '1) evict_q <= evict_q + 1'b1;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			out_outcome <= outcome;
			out_last    <= cmd.last;
			out_hits    <= (hit && hits_q != '1) ? hits_q + 1'b1 : hits_q;
			out_misses  <= (!hit && miss_q != '1) ? miss_q + 1'b1 : miss_q;
			out_evicts  <= (!hit && !inv && evict_q != '1) ? evict_q + 1'b1 : evict_q;
		end
	end

endmodule

/* rtl/set_assoc_lru_cache_lookup.sv */
// Operation: a word is accepted and its set read into a register; the lookup is then resolved,
//   written back and its result registered when the result register is free; a modify word
//   rereads the set for its second lookup. One word is taken at a time: s_tready stays low until
//   its last lookup, as the set memory has a single read/write port for read and write back.
// Reset: asynchronous, active low; afterwards a sweep over all 2**MAX_SET_BITS sets clears
//   valid bits and LRU ranks, s_tready staying low; configuration writes are taken throughout.
`timescale 1ns / 1ps
module set_assoc_lru_cache_lookup
	import salc_pkg::*;
#(
	parameter int MAX_SET_BITS = 10,
	parameter int MAX_WAYS     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB-style configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input words
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // [63:0] address
	input  logic         s_tuser,   // [0] kind (1 = modify)
	// result words
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [1:0] outcome, [33:2] hits_total,
	                                // [65:34] misses_total, [97:66] evictions_total, rest 0
	output logic         m_tlast    // last lookup of the input word
);

	cmd_t  cmd;
	stat_t stat;

	logic [3:0]       set_bits, ways_in_use;
	logic [5:0]       block_bits;
	logic [1:0]       outcome;
	logic [CNT_W-1:0] hits, misses, evicts;

	salc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.set_bits   (set_bits),
		.ways_in_use(ways_in_use),
		.block_bits (block_bits)
	);

	// Controller: clearing sweep, then idle / lookup / reread for the second half of a modify.
	salc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Datapath: one row per set holds valid bits, ranks and tags of all ways.
	salc_dp #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.set_bits   (set_bits),
		.ways_in_use(ways_in_use),
		.block_bits (block_bits),
		.in_addr    (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_outcome(outcome),
		.out_last   (m_tlast),
		.out_hits   (hits),
		.out_misses (misses),
		.out_evicts (evicts)
	);

	assign m_tdata = {6'd0, evicts, misses, hits, outcome};

endmodule

/* rtl/salc_chk.sv */
// Port-level checker of the cache lookup block, bound to the top level.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_lookup_macros.svh"
module salc_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);

	`SALC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word dropped or changed while stalled")
	`SALC_ASSERT_NOW(a_outcome_code, m_tvalid, m_tdata[1:0] != 2'd3, "undefined outcome code")
	`SALC_ASSERT_NOW(a_evict_le_miss, m_tvalid, m_tdata[97:66] <= m_tdata[65:34], "evictions exceed misses")
	`SALC_ASSERT_NOW(a_evict_count, m_tvalid && m_tdata[1:0] == 2'd2, m_tdata[97:66] != 32'd0, "eviction reported with zero eviction count")
	`SALC_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second word taken while a lookup is open")

endmodule

bind set_assoc_lru_cache_lookup salc_chk u_salc_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

/* tb/set_assoc_lru_cache_lookup_test.sv */
// Self-checking testbench for the set-associative LRU cache lookup block.
`timescale 1ns / 1ps
module set_assoc_lru_cache_lookup_test;
	import salc_pkg::*;

	localparam int SETS_MAX  = 10;
	localparam int WAYS_MAX  = 8;
	localparam int LINES     = (1 << SETS_MAX) * WAYS_MAX;
	localparam int CYCLE_CAP = 600000;

	// one lookup result as the block reports it
	typedef struct {
		logic [1:0]  outcome;
		logic        last;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evicts;
	} lookup_res_t;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;   // [63:0] address
	logic         s_tuser;   // [0] kind
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;   // [1:0] outcome, [33:2] hits, [65:34] misses, [97:66] evictions
	logic         m_tlast;

	set_assoc_lru_cache_lookup u_top (.*);

	// shadow copy of the tag store
	bit          line_ok [LINES];
	bit [63:0]   line_tag [LINES];
	bit [2:0]    line_age [LINES];
	bit [31:0]   hit_cnt, miss_cnt, evict_cnt;
	bit [3:0]    cfg_sets;
	bit [3:0]    cfg_ways;
	bit [5:0]    cfg_block;

	lookup_res_t pending_q[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          fails;
	int          cycles;
	int          words_sent;
	int          results_seen;
	int          n_hit, n_fill, n_evict;
	bit [63:0]   addr_pool[24];

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("timeout with %0d results outstanding", pending_q.size());
			$display("set_assoc_lru_cache_lookup_test: FAIL");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// result checker: values seen here are the ones before this edge's updates
	always @(posedge clk) begin
		lookup_res_t w;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result word %h last %b", m_tdata, m_tlast);
			end else begin
				w = pending_q.pop_front();
				if (m_tdata[1:0] !== w.outcome || m_tlast !== w.last ||
				    m_tdata[33:2] !== w.hits || m_tdata[65:34] !== w.misses ||
				    m_tdata[97:66] !== w.evicts || m_tdata[103:98] !== '0) begin
					fails++;
					if (fails <= 10)
						$display("mismatch: want o%0d l%0d h%0d m%0d e%0d, got o%0d l%0d h%0d m%0d e%0d",
							w.outcome, w.last, w.hits, w.misses, w.evicts,
							m_tdata[1:0], m_tlast, m_tdata[33:2], m_tdata[65:34], m_tdata[97:66]);
				end
			end
		end
	end

	function automatic bit [63:0] shift_r(bit [63:0] x, int n);
		return (n >= 64) ? 64'd0 : x >> n;
	endfunction

	function automatic bit [63:0] shift_l(bit [63:0] x, int n);
		return (n >= 64) ? 64'd0 : x << n;
	endfunction

	function automatic void promote(int base, int w);
		int old;
		old = line_ok[base + w] ? int'(line_age[base + w]) : WAYS_MAX;
		for (int v = 0; v < WAYS_MAX; v++)
			if (v != w && line_ok[base + v] && line_age[base + v] < old &&
			    line_age[base + v] < WAYS_MAX - 1)
				line_age[base + v]++;
		line_age[base + w] = 0;
		line_ok[base + w] = 1;
	endfunction

	function automatic bit [31:0] bump(bit [31:0] c);
		return (c == 32'hffff_ffff) ? c : c + 32'd1;
	endfunction

	// one lookup against the shadow store; returns the outcome code
	function automatic logic [1:0] cache_lookup(bit [63:0] addr);
		int s, e, b, base, victim, oldest;
		bit [63:0] tag, set;
		s = (int'(cfg_sets) > SETS_MAX) ? SETS_MAX : int'(cfg_sets);
		e = (cfg_ways == 0) ? 1 : ((int'(cfg_ways) > WAYS_MAX) ? WAYS_MAX : int'(cfg_ways));
		b = int'(cfg_block);
		tag = shift_r(addr, b + s);
		set = shift_r(addr, b) & ((64'd1 << s) - 64'd1);
		base = int'(set) * WAYS_MAX;
		for (int w = 0; w < e; w++)
			if (line_ok[base + w] && line_tag[base + w] == tag) begin
				promote(base, w);
				hit_cnt = bump(hit_cnt);
				return OUT_HIT;
			end
		for (int w = 0; w < e; w++)
			if (!line_ok[base + w]) begin
				line_tag[base + w] = tag;
				promote(base, w);
				miss_cnt = bump(miss_cnt);
				return OUT_FILL;
			end
		victim = 0;
		oldest = int'(line_age[base]);
		for (int w = 1; w < e; w++)
			if (int'(line_age[base + w]) > oldest) begin
				oldest = int'(line_age[base + w]);
				victim = w;
			end
		line_tag[base + victim] = tag;
		promote(base, victim);
		miss_cnt = bump(miss_cnt);
		evict_cnt = bump(evict_cnt);
		return OUT_EVICT;
	endfunction

	function automatic void predict_word(logic kind, bit [63:0] addr);
		lookup_res_t r;
		int n;
		n = (kind == KIND_MODIFY) ? 2 : 1;
		for (int k = 0; k < n; k++) begin
			r.outcome = cache_lookup(addr);
			r.last = (k == n - 1);
			r.hits = hit_cnt;
			r.misses = miss_cnt;
			r.evicts = evict_cnt;
			case (r.outcome)
				OUT_HIT:  n_hit++;
				OUT_FILL: n_fill++;
				default:  n_evict++;
			endcase
			pending_q.push_back(r);
		end
	endfunction

	task automatic send_word(logic kind, bit [63:0] addr);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= addr;
		do @(posedge clk); while (!s_tready);
		predict_word(kind, addr);
		words_sent++;
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_SET_BITS: cfg_sets = val[3:0];
			REG_WAYS:     cfg_ways = val[3:0];
			default:      cfg_block = val[5:0];
		endcase
	endtask

	// let all results drain, then wait out any tail of work
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic configure(int sb, int wy, int bb);
		reg_write(REG_SET_BITS, sb);
		reg_write(REG_WAYS, wy);
		reg_write(REG_BLOCK_BITS, bb);
	endtask

	function automatic bit [63:0] build_addr(bit [63:0] tag, bit [63:0] set, bit [63:0] off);
		int s, b;
		s = (int'(cfg_sets) > SETS_MAX) ? SETS_MAX : int'(cfg_sets);
		b = int'(cfg_block);
		return shift_l(tag, b + s) | (shift_l(set, b) & shift_l((64'd1 << s) - 64'd1, b)) |
			(off & ((64'd1 << b) - 64'd1));
	endfunction

	// cold misses, re-hit, extremes of the address
	task automatic test_fill_and_hit;
		configure(4, 2, 4);
		send_word(1'b0, 64'h0);
		send_word(1'b0, 64'h8);                 // same block: hit
		send_word(1'b0, 64'hffff_ffff_ffff_ffff);
		send_word(KIND_MODIFY, 64'h1_0000_0000); // miss then hit in one word
		send_word(1'b0, 64'h100);               // set 0 full: evicts oldest
		send_word(1'b0, 64'h200);               // evicts oldest in set 0
		drain();
	endtask

	// LRU order across four ways, then shrink and regrow the way count
	task automatic test_lru_order;
		configure(2, 4, 3);
		for (int t = 1; t <= 4; t++)
			send_word(1'b0, build_addr(64'(t), 64'd1, 64'd0));
		send_word(1'b0, build_addr(64'd1, 64'd1, 64'd7));   // refresh tag 1
		send_word(1'b0, build_addr(64'd9, 64'd1, 64'd0));   // evicts tag 2
		drain();
		reg_write(REG_WAYS, 1);
		send_word(1'b0, build_addr(64'd3, 64'd1, 64'd0));   // only way 0 searched
		drain();
		reg_write(REG_WAYS, 4);
		send_word(1'b0, build_addr(64'd4, 64'd1, 64'd0));   // kept line still hits
		drain();
	endtask

	// zero set bits, saturated fields, shifts past the word width
	task automatic test_odd_config;
		configure(0, 0, 0);
		send_word(1'b0, 64'h5);
		send_word(KIND_MODIFY, 64'h6);
		drain();
		configure(15, 15, 63);
		send_word(1'b0, 64'h8000_0000_0000_0000);
		send_word(1'b0, 64'h1);
		drain();
		configure(10, 8, 32);
		send_word(1'b0, 64'hdead_beef_0000_0000);
		send_word(KIND_MODIFY, 64'h0000_0000_dead_beef);
		drain();
	endtask

	task automatic test_random(int n_words, int idle, int stall);
		int sb, wy, bb, pick;
		bit [63:0] a;
		case ($urandom_range(0, 3))
			0: begin sb = 10; wy = 8; bb = 0; end
			1: begin sb = 0;  wy = 1; bb = 63; end
			default: begin
				sb = $urandom_range(0, 15);
				wy = $urandom_range(0, 15);
				bb = $urandom_range(0, 63);
			end
		endcase
		configure(sb, wy, bb);
		// up to four sets, each shared by several tags, so hits and evictions both occur
		for (int i = 0; i < 24; i++)
			addr_pool[i] = build_addr({$urandom, $urandom} & ((i % 3 == 0) ? 64'hf : '1),
				64'(i % 4), 64'd0);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n_words; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				a = addr_pool[$urandom_range(0, 23)] |
					(shift_l(64'd1, int'(cfg_block)) - 64'd1 & {$urandom, $urandom});
			else if (pick < 85)
				a = build_addr(addr_pool[$urandom_range(0, 23)] >> 40, 64'($urandom),
					64'($urandom));
			else
				a = {$urandom, $urandom};
			send_word(1'($urandom_range(0, 1)), a);
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_sets = RST_SET_BITS;
		cfg_ways = RST_WAYS;
		cfg_block = RST_BLOCK_BITS;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_hit();
		test_lru_order();
		test_odd_config();
		test_random(175, 0, 0);
		test_random(175, 83, 0);
		test_random(175, 0, 83);
		test_random(175, 20, 20);

		$display("%0d input words, %0d lookups checked: %0d hits, %0d fills, %0d evictions",
			words_sent, results_seen, n_hit, n_fill, n_evict);
		$display("covered saturated and zero settings, way shrink and regrow, four idling mixes");
		if (fails == 0 && pending_q.size() == 0) begin
			$display("set_assoc_lru_cache_lookup_test: PASS");
		end else begin
			$display("%0d failures", fails + pending_q.size());
			$display("set_assoc_lru_cache_lookup_test: FAIL");
		end
		$finish;
	end

endmodule
